/* hw/rtl/hsp_pkg.sv */
// hsp_pkg: shared types and constants of the half-speed segment player.
// Used by hsp_ctrl, hsp_datapath, half_speed_segment_player, hsp_checker and tb; no dependencies.

package hsp_pkg;

  // Configuration register widths and reset values.
  localparam int SEG_LEN_W = 18;
  localparam int FADE_W    = 17;

  localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 18'd24000;
  localparam logic [FADE_W-1:0]    FADE_RESET    = 17'd0;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH    = 1'b1;

  // Q16 fade gain: 17 bits so that unity (65536) fits.
  localparam int GAIN_W  = 17;
  localparam int FRAC_W  = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // Divider: one quotient bit per cycle, integer bit plus 16 fraction bits.
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
  localparam int REM_W = FADE_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_GAIN,
    S_AVG,
    S_DIV,
    S_MUL,
    S_ROUND,
    S_HOLD
  } hsp_state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic capture;   // latch the input request
    logic phase;     // phase update, store write or pass-through
    logic gain;      // store read, fade gain selection, divider start
    logic avg;       // interpolation, previous-entry update
    logic mul;       // fade multiply
    logic round;     // truncate product into the result registers
    logic out_load;  // move result into the output register
  } hsp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic playing;
    logic div_done;
    logic out_free;
  } hsp_stat_t;

endpackage

/* hw/rtl/hsp_ctrl.sv */
// hsp_ctrl: sequencing state machine of the half-speed segment player.
// Depends on hsp_pkg (state enum, command and status structs).

module hsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsp_pkg::hsp_stat_t stat,
  output hsp_pkg::hsp_cmd_t  cmd
);

  hsp_pkg::hsp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hsp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = hsp_pkg::S_PHASE;
        end
      end
      hsp_pkg::S_PHASE: begin
        cmd.phase = 1'b1;
        // pass-through requests skip the whole effect path
        state_nxt = stat.playing ? hsp_pkg::S_GAIN : hsp_pkg::S_HOLD;
      end
      hsp_pkg::S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = hsp_pkg::S_AVG;
      end
      hsp_pkg::S_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = hsp_pkg::S_DIV;
      end
      hsp_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_nxt = hsp_pkg::S_MUL;
        end
      end
      hsp_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = hsp_pkg::S_ROUND;
      end
      hsp_pkg::S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = hsp_pkg::S_HOLD;
      end
      hsp_pkg::S_HOLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = hsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hsp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/hsp_datapath.sv */
// hsp_datapath: config registers, segment store, phase counter, fade divider,
// interpolation, fade multiply and output register. Depends on hsp_pkg.

module hsp_datapath #(
  parameter int SEGMENT_DEPTH = 131072,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [hsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hsp_pkg::SEG_LEN_W-1:0]       cfg_wdata,
  // input payload
  input  logic                                in_playing,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_right_in,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right_out,
  // controller link
  input  hsp_pkg::hsp_cmd_t                   cmd,
  output hsp_pkg::hsp_stat_t                  stat
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = $clog2(SEGMENT_DEPTH);
  localparam int PW   = $clog2(2 * SEGMENT_DEPTH);
  localparam int LW   = $clog2(SEGMENT_DEPTH + 1);
  localparam int CW   = LW + 1;
  localparam int CMPW = (LW > hsp_pkg::SEG_LEN_W) ? LW : hsp_pkg::SEG_LEN_W;
  localparam int XW   = (LW > hsp_pkg::FADE_W) ? LW : hsp_pkg::FADE_W;
  localparam int PRW  = SW + hsp_pkg::GAIN_W + 1;

  // ---------------------------------------------------------------- config
  logic [hsp_pkg::SEG_LEN_W-1:0] seg_len_r;
  logic [hsp_pkg::FADE_W-1:0]    fade_len_r;
  logic [LW-1:0]                 len_r, len_nxt;
  logic [CMPW-1:0]               seg_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_len_r  <= hsp_pkg::SEG_LEN_RESET;
      fade_len_r <= hsp_pkg::FADE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hsp_pkg::REG_SEGMENT_LENGTH: seg_len_r  <= cfg_wdata;
        hsp_pkg::REG_FADE_LENGTH:    fade_len_r <= cfg_wdata[hsp_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp L to 1..SEGMENT_DEPTH, registered off the request path
  always_comb begin
    seg_ext = CMPW'(seg_len_r);
    if (seg_ext == '0) begin
      len_nxt = LW'(1);
    end else if (seg_ext > CMPW'(SEGMENT_DEPTH)) begin
      len_nxt = LW'(SEGMENT_DEPTH);
    end else begin
      len_nxt = LW'(seg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(1);
    end else begin
      len_r <= len_nxt;
    end
  end

  // ---------------------------------------------------------------- request
  logic                 play_r;
  logic signed [SW-1:0] lin_r, rin_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      play_r <= in_playing;
      lin_r  <= in_left_in;
      rin_r  <= in_right_in;
    end
  end

  // ---------------------------------------------------------------- phase
  logic [PW-1:0] phase_r;
  logic [CW-1:0] two_len, ph_ext, p_eff, p_inc, p_nxt;
  logic          wrap, store_wr;
  logic [AW-1:0] r_r;
  logic          p_odd_r;

  always_comb begin
    two_len  = {len_r, 1'b0};
    ph_ext   = CW'(phase_r);
    wrap     = (ph_ext >= two_len);
    p_eff    = wrap ? '0 : ph_ext;
    store_wr = (p_eff < CW'(len_r));
    p_inc    = p_eff + CW'(1);
    p_nxt    = (p_inc >= two_len) ? '0 : p_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.phase) begin
      phase_r <= play_r ? PW'(p_nxt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase) begin
      r_r     <= AW'(p_eff >> 1);
      p_odd_r <= p_eff[0];
    end
  end

  // ---------------------------------------------------------------- store
  logic [2*SW-1:0] store_mem [SEGMENT_DEPTH];
  logic [2*SW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (cmd.phase && play_r && store_wr) begin
      store_mem[AW'(p_eff)] <= {lin_r, rin_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      rd_r <= store_mem[r_r];
    end
  end

  // ---------------------------------------------------------------- gain
  logic [LW-1:0]                dist_end;
  logic                         fade_on, in_sel, out_sel;
  logic [hsp_pkg::FADE_W-1:0]   gain_x;
  logic [hsp_pkg::REM_W-1:0]    rem_r, rem_t, fade_ext;
  logic [hsp_pkg::GAIN_W-1:0]   quot_r, gain;
  logic [hsp_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic                         bypass_r, div_busy, div_ge;

  always_comb begin
    dist_end = len_r - LW'(r_r);
    fade_on  = (fade_len_r != '0);
    in_sel   = fade_on && (XW'(r_r) <= XW'(fade_len_r));
    out_sel  = fade_on && (XW'(dist_end) <= XW'(fade_len_r));
    // fade-out wins over fade-in
    gain_x   = out_sel ? hsp_pkg::FADE_W'(dist_end) : hsp_pkg::FADE_W'(r_r);
  end

  // restoring divider: x * 2^16 / F, integer bit first
  always_comb begin
    div_busy = (div_cnt_r != hsp_pkg::DIV_STEPS);
    fade_ext = hsp_pkg::REM_W'(fade_len_r);
    rem_t    = (div_cnt_r == '0) ? rem_r : {rem_r[hsp_pkg::REM_W-2:0], 1'b0};
    div_ge   = (rem_t >= fade_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= hsp_pkg::DIV_STEPS;
    end else if (cmd.gain) begin
      div_cnt_r <= (in_sel || out_sel) ? '0 : hsp_pkg::DIV_STEPS;
    end else if (div_busy) begin
      div_cnt_r <= div_cnt_r + hsp_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      rem_r    <= hsp_pkg::REM_W'(gain_x);
      bypass_r <= !(in_sel || out_sel);
    end else if (div_busy) begin
      rem_r  <= div_ge ? (rem_t - fade_ext) : rem_t;
      quot_r <= {quot_r[hsp_pkg::GAIN_W-2:0], div_ge};
    end
  end

  assign gain = bypass_r ? hsp_pkg::GAIN_ONE : quot_r;

  // ---------------------------------------------------------------- interpolation
  logic signed [SW-1:0] cur_l, cur_r, prev_l_r, prev_r_r, pm_l, pm_r;
  logic signed [SW:0]   sum_l, sum_r, adj_l, adj_r;
  logic signed [SW-1:0] avg_l_r, avg_r_r;

  always_comb begin
    cur_l = rd_r[2*SW-1:SW];
    cur_r = rd_r[SW-1:0];
    pm_l  = (r_r == '0) ? '0 : prev_l_r;
    pm_r  = (r_r == '0) ? '0 : prev_r_r;
    sum_l = {cur_l[SW-1], cur_l} + {pm_l[SW-1], pm_l};
    sum_r = {cur_r[SW-1], cur_r} + {pm_r[SW-1], pm_r};
    // halve toward zero
    adj_l = sum_l + (SW+1)'(sum_l[SW] & sum_l[0]);
    adj_r = sum_r + (SW+1)'(sum_r[SW] & sum_r[0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.avg) begin
      avg_l_r <= p_odd_r ? cur_l : SW'(adj_l >>> 1);
      avg_r_r <= p_odd_r ? cur_r : SW'(adj_r >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r <= '0;
      prev_r_r <= '0;
    end else if (cmd.phase && (!play_r || wrap)) begin
      prev_l_r <= '0;
      prev_r_r <= '0;
    end else if (cmd.avg && p_odd_r) begin
      prev_l_r <= cur_l;
      prev_r_r <= cur_r;
    end
  end

  // ---------------------------------------------------------------- fade multiply
  logic signed [hsp_pkg::GAIN_W:0] gain_s;
  logic signed [PRW-1:0]           prod_l_r, prod_r_r, shr_l, shr_r;

  assign gain_s = {1'b0, gain};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= PRW'(avg_l_r * gain_s);
      prod_r_r <= PRW'(avg_r_r * gain_s);
    end
  end

  always_comb begin
    shr_l = (prod_l_r >>> hsp_pkg::FRAC_W)
          + PRW'(prod_l_r[PRW-1] & (|prod_l_r[hsp_pkg::FRAC_W-1:0]));
    shr_r = (prod_r_r >>> hsp_pkg::FRAC_W)
          + PRW'(prod_r_r[PRW-1] & (|prod_r_r[hsp_pkg::FRAC_W-1:0]));
  end

  // ---------------------------------------------------------------- result / output
  logic signed [SW-1:0] res_l_r, res_r_r;
  logic signed [SW-1:0] out_l_r, out_r_r;
  logic                 out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.phase && !play_r) begin
      res_l_r <= lin_r;
      res_r_r <= rin_r;
    end else if (cmd.round) begin
      res_l_r <= SW'(shr_l);
      res_r_r <= SW'(shr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r <= res_l_r;
      out_r_r <= res_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

  assign stat.playing  = play_r;
  assign stat.div_done = !div_busy;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

/* hw/rtl/half_speed_segment_player.sv */
// half_speed_segment_player: top level, stereo half-speed segment playback.
// Depends on hsp_pkg, hsp_ctrl and hsp_datapath.
//
//   channel | ports                                   | transfer
//   --------+-----------------------------------------+-------------------------
//   in      | in_valid/in_ready, in_playing,          | one request per sample
//           | in_left_in, in_right_in                 |
//   out     | out_valid/out_ready, out_left_out,      | one result per request
//           | out_right_out                           |
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata         | write only, no wait
//
// Sequence: one request at a time. A pass-through request (playing low) skips
// the effect path; a playing request inside a fade region also waits in the
// divide step for the fade gain divider (one quotient bit per cycle, 17 bits).
// Reset: synchronous, active low; segment_length returns to 24000, fade to 0,
// phase and previous entries to zero. The segment store is not cleared.
// Stalls: the result sits in an output register, so the next request is taken
// while out_ready is low; only a second finished result waits for the first.

module half_speed_segment_player #(
  parameter int SEGMENT_DEPTH = 131072,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [hsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hsp_pkg::SEG_LEN_W-1:0]    cfg_wdata,
  // input requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_playing,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_right_in,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]   out_right_out
);

  hsp_pkg::hsp_cmd_t  cmd;
  hsp_pkg::hsp_stat_t stat;

  // sequencer: accept, phase/store write, gain select, interpolate,
  // divide, multiply, truncate, hand off
  hsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // all storage and arithmetic, including the segment store
  hsp_datapath #(
    .SEGMENT_DEPTH (SEGMENT_DEPTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_playing    (in_playing),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

/* test/hsp_checker.sv */
`timescale 1ns / 100ps
// hsp_checker: watches the config, request and result ports of the half-speed
// segment player, predicts every result and compares it field by field.
// Depends on hsp_pkg only.

module hsp_checker
  import hsp_pkg::*;
#(
  parameter int SEGMENT_DEPTH = 131072,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [SEG_LEN_W-1:0]           cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_playing,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  input  logic signed [SAMPLE_WIDTH-1:0] out_right_out,
  output int                             fail_count,
  output int                             pending
);

  localparam longint UNITY = longint'(1) << FRAC_W;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
  } stereo_t;

  logic [SEG_LEN_W-1:0] seg_len;
  logic [FADE_W-1:0]    fade_len;
  longint               phase;
  longint               prev_left;
  longint               prev_right;
  int                   seg_left  [SEGMENT_DEPTH];
  int                   seg_right [SEGMENT_DEPTH];
  stereo_t              owed[$];

  // One step of the player: capture, half-speed read, interpolation, fade.
  function automatic stereo_t play_step(logic playing,
                                        logic signed [SAMPLE_WIDTH-1:0] l_in,
                                        logic signed [SAMPLE_WIDTH-1:0] r_in);
    longint  len, fade, p, idx, cur_l, cur_r, avg_l, avg_r, gain;
    stereo_t res;
    if (!playing) begin
      phase      = 0;
      prev_left  = 0;
      prev_right = 0;
      res.left   = l_in;
      res.right  = r_in;
      return res;
    end
    len = seg_len;
    if (len == 0) len = 1;
    if (len > SEGMENT_DEPTH) len = SEGMENT_DEPTH;
    fade = fade_len;
    p = phase;
    // segment shortened below the current position: start over
    if (p >= 2 * len) begin
      p          = 0;
      prev_left  = 0;
      prev_right = 0;
    end
    if (p < len) begin
      seg_left[p]  = l_in;
      seg_right[p] = r_in;
    end
    idx   = p / 2;
    cur_l = seg_left[idx];
    cur_r = seg_right[idx];
    if (p % 2 == 0) begin
      avg_l = (cur_l + ((idx == 0) ? 0 : prev_left)) / 2;
      avg_r = (cur_r + ((idx == 0) ? 0 : prev_right)) / 2;
    end else begin
      avg_l      = cur_l;
      avg_r      = cur_r;
      prev_left  = cur_l;
      prev_right = cur_r;
    end
    gain = UNITY;
    if (fade != 0) begin
      if (idx <= fade) gain = idx * UNITY / fade;
      // fade-out wins where both ramps overlap
      if (len - idx <= fade) gain = (len - idx) * UNITY / fade;
    end
    res.left  = (avg_l * gain) / UNITY;
    res.right = (avg_r * gain) / UNITY;
    p++;
    if (p >= 2 * len) p = 0;
    phase = p;
    return res;
  endfunction

  always @(posedge clk) begin
    stereo_t want;
    if (!rst_n) begin
      seg_len    = SEG_LEN_RESET;
      fade_len   = FADE_RESET;
      phase      = 0;
      prev_left  = 0;
      prev_right = 0;
      owed.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d",
                 out_left_out, out_right_out);
          fail_count++;
        end else begin
          want = owed.pop_front();
          if (out_left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, out_left_out);
            fail_count++;
          end
          if (out_right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, out_right_out);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SEGMENT_LENGTH: seg_len  = cfg_wdata;
          REG_FADE_LENGTH:    fade_len = cfg_wdata[FADE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        owed.push_back(play_step(in_playing, in_left_in, in_right_in));
    end
    pending <= owed.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// tb: clock, reset, request/config stimulus and verdict for the half-speed
// segment player. Depends on hsp_pkg, hsp_checker and the player RTL.

module tb;
  import hsp_pkg::*;

  localparam int DEPTH       = 131072;
  localparam int SW          = 24;
  localparam int REQUESTS    = 1550;
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = REG_SEGMENT_LENGTH;
  logic [SEG_LEN_W-1:0]   cfg_wdata   = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_playing  = 1'b0;
  logic signed [SW-1:0]   in_left_in  = '0;
  logic signed [SW-1:0]   in_right_in = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic signed [SW-1:0]   out_left_out;
  logic signed [SW-1:0]   out_right_out;
  int                     fail_count;
  int                     pending;

  int     cycles     = 0;
  int     sent       = 0;   // requests taken by the block
  int     burst_left = 0;   // requests left before the next sender gap
  int     max_gap    = 3;   // longest sender gap in the current phase
  int     ready_hold = 0;   // cycles until the receiver picks a new out_ready
  longint cur_len    = SEG_LEN_RESET;  // segment length as the block applies it

  half_speed_segment_player #(.SEGMENT_DEPTH(DEPTH), .SAMPLE_WIDTH(SW)) dut (.*);

  hsp_checker #(.SEGMENT_DEPTH(DEPTH), .SAMPLE_WIDTH(SW)) player_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: rotates through always-ready, short random toggles and long
  // stalls so that back-pressure lands on the block's result hand-off.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ((cycles / 2048) % 3)
        0: begin
          out_ready  <= 1'b1;
          ready_hold <= 0;
        end
        1: begin
          out_ready  <= 1'($urandom_range(0, 1));
          ready_hold <= $urandom_range(0, 3);
        end
        default: begin
          if (out_ready) begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(5, 60);
          end else begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 4);
          end
        end
      endcase
    end
  end

  // Mostly full-range noise, with the rails and values around zero mixed in.
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and return at the edge that takes it. Gaps fall only
  // between bursts; inside a burst valid stays high from request to request.
  task automatic send(input logic playing, input logic signed [SW-1:0] left,
                      input logic signed [SW-1:0] right);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_playing  <= playing;
    in_left_in  <= left;
    in_right_in <= right;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold off until every result owed has been taken. The first edge lets the
  // checker's count catch up with a request taken on the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Reprogram both registers on an idle block. A longer segment would read
  // entries not yet captured in this pass, so a pass-through request restarts
  // the cycle first; a shorter one is left alone so the wrap logic gets hit.
  task automatic configure(input logic [SEG_LEN_W-1:0] seg,
                           input logic [SEG_LEN_W-1:0] fade);
    longint was;
    was = cur_len;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SEGMENT_LENGTH;
    cfg_wdata <= seg;
    @(posedge clk);
    cfg_index <= REG_FADE_LENGTH;
    cfg_wdata <= fade;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = (seg == 0) ? 1 : (seg > DEPTH) ? DEPTH : seg;
    if (cur_len > was) send(1'b0, pick_sample(), pick_sample());
  endtask

  initial begin
    int seg;
    int fade;
    int span;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: rails through pass-through, then the first playing steps.
    send(1'b0, S_MAX, S_MIN);
    send(1'b0, S_MIN, S_MAX);
    send(1'b1, S_MAX, S_MIN);
    send(1'b1, S_MIN, S_MAX);

    // Short segment: positions past the segment drop their input.
    configure(3, 0);
    repeat (4) send(1'b1, pick_sample(), pick_sample());

    // Zero length behaves as one.
    configure(0, 0);
    repeat (2) send(1'b1, pick_sample(), pick_sample());

    // Length above the store depth is clamped; fade length 65536.
    configure('1, 65536);
    repeat (2) send(1'b1, pick_sample(), pick_sample());

    // Fade-in and fade-out overlap on a tiny segment.
    configure(4, 2);
    repeat (8) send(1'b1, pick_sample(), pick_sample());

    // Fade with the register's spare top bit set, then shorten mid-cycle
    // so the position already sits past the new cycle end.
    configure(20, '1);
    repeat (8) send(1'b1, pick_sample(), pick_sample());
    configure(4, 0);
    send(1'b1, pick_sample(), pick_sample());

    // Random phases: mostly short segments so cycles wrap many times.
    while (sent < REQUESTS) begin
      case ($urandom_range(0, 19))
        0: begin
          case ($urandom_range(0, 4))
            0:       seg = 0;
            1:       seg = 1;
            2:       seg = DEPTH;
            3:       seg = DEPTH + 1;
            default: seg = (1 << SEG_LEN_W) - 1;
          endcase
        end
        1, 2:    seg = $urandom_range(0, (1 << SEG_LEN_W) - 1);
        3, 4, 5: seg = $urandom_range(41, 600);
        default: seg = $urandom_range(1, 40);
      endcase
      span = (seg == 0) ? 1 : (seg > DEPTH) ? DEPTH : seg;
      case ($urandom_range(0, 9))
        0, 1, 2: fade = 0;
        3:       fade = $urandom_range(0, (1 << SEG_LEN_W) - 1);
        4:       fade = $urandom_range(0, 1) ? 65536 : 1;
        5, 6:    fade = $urandom_range(span / 2, span + 4);
        default: fade = $urandom_range(1, span / 2 + 1);
      endcase
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      configure(seg, fade);
      repeat ($urandom_range(10, 80))
        send(1'($urandom_range(0, 15) != 0), pick_sample(), pick_sample());
    end

    wait_drained();
    // room for a stray extra result to surface
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
